// ===== rtl/sawr_pkg.sv =====
package sawr_pkg;

  // Input item function codes.
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_WORD  = 2'd1,
    FUNC_PIGGY = 2'd2
  } func_e;

  // Received frame kinds, sampled with the last word.
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_NAK  = 2'd2
  } kind_e;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_NOTIFY  = 3'd0,
    EV_NAK     = 3'd1,
    EV_ACK     = 3'd2,
    EV_DELIVER = 3'd3,
    EV_DUP     = 3'd4,
    EV_PIGGY   = 3'd5
  } event_e;

  localparam logic [15:0] SUM_VALID         = 16'hFFFF;
  localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd1000;
  localparam logic [16:0] AGE_MAX           = 17'h1FFFF;

  // One input word.
  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] frame_word;
    logic        last_word;
    logic [1:0]  frame_kind;
    logic        frame_seq;
    logic        frame_ack;
    logic        carries_ack;
    logic        last_chunk;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [2:0]  event_res;
    logic        notify_nak;
    logic        seq_value;
    logic        piggy_present;
    logic        message_end;
    logic [15:0] folded_sum;
    logic        last;
  } out_word_t;

endpackage

// ===== rtl/stop_and_wait_receiver_piggyback_ack_core.sv =====
// Receive side of a stop-and-wait ARQ link with a one-bit sequence number. Each input word
// is a tick, a received frame word or a piggyback request; frame words are summed in 16-bit
// ones' complement and the header fields are taken with the last word. The block takes one
// input word per cycle and decides it in that same cycle; its results go into a four-entry
// result queue, and input is taken while at least two entries are free. An item yields zero,
// one or two results, and the output side drains one result per cycle while out_ready_i is
// high; a data frame with a piggybacked ACK yields two results. The user writes ack_timeout
// via its own always-ready channel only while the block is idle, which the core does not enforce.
module stop_and_wait_receiver_piggyback_ack_core
  import sawr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_data_o
);

  // Protocol state.
  logic [15:0] ack_timeout_q;
  logic [15:0] sum_acc_q, sum_acc_d;
  logic        expected_seq_q, expected_seq_d;
  logic        pending_valid_q, pending_valid_d;
  logic        pending_seq_q, pending_seq_d;
  logic [16:0] pending_age_q, pending_age_d;
  logic        peer_known_q, peer_known_d;

  // Result queue.
  out_word_t   queue_q [4];
  logic [1:0]  wr_ptr_q, rd_ptr_q;
  logic [2:0]  cnt_q, cnt_d;

  logic        in_fire, out_fire;
  logic [16:0] sum_wide;
  logic [15:0] sum_fold;
  logic [16:0] age_inc;
  logic [1:0]  push_n;
  out_word_t   res0, res1, res_main, res_notify;
  logic        is_word, is_last, is_ctrl;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (cnt_q <= 3'd2);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign out_data_o  = queue_q[rd_ptr_q];

  // Ones' complement add with end-around carry.
  assign sum_wide = {1'b0, sum_acc_q} + {1'b0, in_data_i.frame_word};
  assign sum_fold = sum_wide[15:0] + {15'd0, sum_wide[16]};
  assign age_inc  = (pending_age_q < AGE_MAX) ? pending_age_q + 17'd1 : pending_age_q;

  assign is_word = (in_data_i.func == FUNC_WORD);
  assign is_last = is_word && in_data_i.last_word;
  assign is_ctrl = (in_data_i.frame_kind == KIND_ACK) || (in_data_i.frame_kind == KIND_NAK);

  // Decide the results and the next state for one input word.
  always_comb begin
    sum_acc_d       = sum_acc_q;
    expected_seq_d  = expected_seq_q;
    pending_valid_d = pending_valid_q;
    pending_seq_d   = pending_seq_q;
    pending_age_d   = pending_age_q;
    peer_known_d    = peer_known_q;
    push_n          = 2'd0;
    res0            = '0;
    res1            = '0;
    res_main        = '0;
    res_notify      = '0;

    res_notify.event_res  = EV_NOTIFY;
    res_notify.seq_value  = in_data_i.frame_ack;
    res_notify.folded_sum = sum_fold;
    res_notify.notify_nak = (in_data_i.frame_kind == KIND_NAK);

    res_main.seq_value  = in_data_i.frame_seq;
    res_main.folded_sum = sum_fold;
    res_main.last       = 1'b1;
    if (sum_fold != SUM_VALID) begin
      res_main.event_res = EV_NAK;
    end else if (in_data_i.frame_seq != expected_seq_q) begin
      res_main.event_res = EV_DUP;
    end else begin
      res_main.event_res   = EV_DELIVER;
      res_main.message_end = in_data_i.last_chunk;
    end

    unique case (in_data_i.func)
      FUNC_TICK: begin
        if (pending_valid_q) begin
          pending_age_d = age_inc;
          if ((age_inc > {1'b0, ack_timeout_q}) && peer_known_q) begin
            res0.event_res  = EV_ACK;
            res0.seq_value  = pending_seq_q;
            res0.last       = 1'b1;
            push_n          = 2'd1;
            pending_valid_d = 1'b0;
          end
        end
      end
      FUNC_WORD: begin
        sum_acc_d = sum_fold;
        if (is_last) begin
          sum_acc_d = '0;
          if (is_ctrl) begin
            res0      = res_notify;
            res0.last = 1'b1;
            push_n    = 2'd1;
          end else begin
            peer_known_d = 1'b1;
            if (sum_fold == SUM_VALID) begin
              pending_valid_d = 1'b1;
              pending_seq_d   = in_data_i.frame_seq;
              pending_age_d   = '0;
              if (in_data_i.frame_seq == expected_seq_q) begin
                expected_seq_d = ~expected_seq_q;
              end
            end
            if (in_data_i.carries_ack) begin
              res_notify.notify_nak = 1'b0;
              res0   = res_notify;
              res1   = res_main;
              push_n = 2'd2;
            end else begin
              res0   = res_main;
              push_n = 2'd1;
            end
          end
        end
      end
      FUNC_PIGGY: begin
        res0.event_res     = EV_PIGGY;
        res0.seq_value     = pending_valid_q ? pending_seq_q : 1'b0;
        res0.piggy_present = pending_valid_q;
        res0.last          = 1'b1;
        push_n             = 2'd1;
        pending_valid_d    = 1'b0;
      end
      default: begin
        push_n = 2'd0;
      end
    endcase

    if (!in_fire) begin
      push_n = 2'd0;
    end
    cnt_d = cnt_q + {1'b0, push_n} - {2'd0, out_fire};
  end

  // State and queue control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_timeout_q   <= ACK_TIMEOUT_RESET;
      sum_acc_q       <= '0;
      expected_seq_q  <= 1'b0;
      pending_valid_q <= 1'b0;
      pending_seq_q   <= 1'b0;
      pending_age_q   <= '0;
      peer_known_q    <= 1'b0;
      wr_ptr_q        <= '0;
      rd_ptr_q        <= '0;
      cnt_q           <= '0;
    end else begin
      if (cfg_valid_i) begin
        ack_timeout_q <= cfg_data_i;
      end
      if (in_fire) begin
        sum_acc_q       <= sum_acc_d;
        expected_seq_q  <= expected_seq_d;
        pending_valid_q <= pending_valid_d;
        pending_seq_q   <= pending_seq_d;
        pending_age_q   <= pending_age_d;
        peer_known_q    <= peer_known_d;
      end
      wr_ptr_q <= wr_ptr_q + push_n;
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      cnt_q <= cnt_d;
    end
  end

  // Queue storage; entries need no reset.
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (push_n == 2'd2) begin
      queue_q[wr_ptr_q + 2'd1] <= res1;
    end
  end

  // The queue never holds more than its four entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("result queue overflow");

  // A clean data frame always leaves an acknowledgement pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_last && !is_ctrl && (sum_fold == SUM_VALID)) |=> pending_valid_q)
    else $error("valid data frame left no pending ACK");

  // A piggyback request always consumes the pending acknowledgement.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.func == FUNC_PIGGY)) |=> !pending_valid_q)
    else $error("pending ACK survived a piggyback request");

  // The expected sequence bit moves only when a word is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(expected_seq_q))
    else $error("expected sequence changed without input");

endmodule
